// File: hdl/isrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isrt_pkg
// Shared types and constants for the insertion sorter chain.
// ----------------------------------------------------------------------------
package isrt_pkg;

    localparam int CAPACITY = 64;
    localparam int VALUE_W  = 32;

    typedef logic signed [VALUE_W-1:0] value_t;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic insert;   // insert the broadcast value in sorted position
        logic shift;    // move every entry one cell toward the head
    } cell_ctrl_t;

endpackage

// File: hdl/isrt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isrt_in_if / isrt_out_if
// Valid/ready channels for loaded elements and sorted results.
// ----------------------------------------------------------------------------
interface isrt_in_if
    import isrt_pkg::*;
();
    logic   valid;
    logic   ready;
    value_t value;
    logic   last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface isrt_out_if
    import isrt_pkg::*;
();
    logic   valid;
    logic   ready;
    value_t sorted_value;
    logic   final_res;
    logic   overflow;

    modport source (output valid, output sorted_value, output final_res,
                    output overflow, input ready);
    modport sink   (input valid, input sorted_value, input final_res,
                    input overflow, output ready);
endinterface

// File: hdl/isrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isrt_cell
// One slot of the sorted chain: holds an entry, compares it against the
// broadcast value and trades entries with its neighbors.
// ----------------------------------------------------------------------------
module isrt_cell
    import isrt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  value_t     new_value,
    input  value_t     left_value,
    input  logic       left_valid,
    input  logic       left_lt,
    input  value_t     right_value,
    input  logic       right_valid,
    output value_t     value,
    output logic       valid,
    output logic       lt
);

    value_t value_reg, value_next;
    logic   valid_reg, valid_next;

    // Empty slots act as +infinity so the chain stays monotonic
    assign lt = !valid_reg || (new_value < value_reg);

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.shift)
        begin
            value_next = right_value;
            valid_next = right_valid;
        end
        else if (ctrl.insert && lt)
        begin
            value_next = left_lt ? left_value : new_value;
            valid_next = valid_reg || left_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

// File: hdl/integer_sorter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_sorter
// Collects signed 32-bit elements and emits them in ascending order on the
// element flagged last. While ready, load takes one element per cycle: each
// arriving element is broadcast to a row of CAPACITY cells and every cell
// decides in the same cycle whether to keep its entry, take its left
// neighbor's, or take the new element, so the row is always sorted with the
// smallest entry in cell 0. The accept of a last element starts the drain:
// the first result is valid on the next cycle, and each result taken shifts
// the row one cell toward the head, so results leave at one per cycle while
// the sink is ready. The load side is held off (ready low) from the last
// element until the final result of the set has been taken, and reopens on
// the cycle right after that take. Elements beyond CAPACITY are dropped and
// every result of that set shows overflow. The per-cycle critical path is
// one 32-bit signed compare in each cell plus a 4:1 select (hold, right
// neighbor, left neighbor, new element). No clearing is needed after reset.
// ----------------------------------------------------------------------------
module integer_sorter
    import isrt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    isrt_in_if.sink    load,
    isrt_out_if.source result
);

    // Chain wiring: index CAPACITY is the tail terminator (always empty)
    value_t     cell_value [CAPACITY+1];
    logic       cell_valid [CAPACITY+1];
    logic       cell_lt    [CAPACITY];
    cell_ctrl_t ctrl;

    logic drain_reg,   drain_next;
    logic dropped_reg, dropped_next;
    logic load_take, result_take, full;

    assign full        = cell_valid[CAPACITY-1];
    assign load.ready  = !drain_reg;
    assign load_take   = load.valid && load.ready;
    assign result_take = result.valid && result.ready;

    // Insert only with room; the shift drains from the head
    assign ctrl.insert = load_take && !full;
    assign ctrl.shift  = result_take;

    assign cell_value[CAPACITY] = '0;
    assign cell_valid[CAPACITY] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                // Nothing to the left: a hit here always takes the new value
                isrt_cell u_cell (
                    .clk         (clk),
                    .rst_n       (rst_n),
                    .ctrl        (ctrl),
                    .new_value   (load.value),
                    .left_value  ('0),
                    .left_valid  (1'b1),
                    .left_lt     (1'b0),
                    .right_value (cell_value[gi+1]),
                    .right_valid (cell_valid[gi+1]),
                    .value       (cell_value[gi]),
                    .valid       (cell_valid[gi]),
                    .lt          (cell_lt[gi])
                );
            end
            else
            begin : g_body
                isrt_cell u_cell (
                    .clk         (clk),
                    .rst_n       (rst_n),
                    .ctrl        (ctrl),
                    .new_value   (load.value),
                    .left_value  (cell_value[gi-1]),
                    .left_valid  (cell_valid[gi-1]),
                    .left_lt     (cell_lt[gi-1]),
                    .right_value (cell_value[gi+1]),
                    .right_valid (cell_valid[gi+1]),
                    .value       (cell_value[gi]),
                    .valid       (cell_valid[gi]),
                    .lt          (cell_lt[gi])
                );
            end
        end
    endgenerate

    // Drain runs from the last element's accept to the final result's take.
    // The drop flag covers the whole set, including a drop on the last item.
    always_comb
    begin
        drain_next   = drain_reg;
        dropped_next = dropped_reg;
        if (drain_reg)
        begin
            if (result_take && result.final_res)
            begin
                drain_next   = 1'b0;
                dropped_next = 1'b0;
            end
        end
        else if (load_take)
        begin
            drain_next = load.last;
            if (full)
            begin
                dropped_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_reg   <= 1'b0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            drain_reg   <= drain_next;
            dropped_reg <= dropped_next;
        end
    end

    // Head cell is the output register; the item is final once cell 1 is empty
    assign result.valid        = drain_reg && cell_valid[0];
    assign result.sorted_value = cell_value[0];
    assign result.final_res    = !cell_valid[1];
    assign result.overflow     = dropped_reg;

endmodule

// File: hdl/isrt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isrt_checker
// Port-level checks on the sorter's load/drain sequencing, bound to the top.
// ----------------------------------------------------------------------------
module isrt_checker
    import isrt_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic load_valid,
    input logic load_ready,
    input logic load_last,
    input logic result_valid,
    input logic result_ready,
    input logic result_final,
    input logic result_overflow
);

    // Load and drain never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(load_ready && result_valid))
        else $error("load ready while results pending");

    // The last element starts the burst on the next cycle
    a_burst_start: assert property (@(posedge clk) disable iff (!rst_n)
        (load_valid && load_ready && load_last) |=> result_valid)
        else $error("no result after last element");

    // Taking the final result reopens the load side
    a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_ready && result_final) |=> load_ready)
        else $error("load not reopened after final result");

    // A burst continues past a non-final result with the same overflow flag
    a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_ready && !result_final)
            |=> (result_valid && $stable(result_overflow)))
        else $error("burst broken or overflow changed");

endmodule

bind integer_sorter isrt_checker u_isrt_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .load_valid      (load.valid),
    .load_ready      (load.ready),
    .load_last       (load.last),
    .result_valid    (result.valid),
    .result_ready    (result.ready),
    .result_final    (result.final_res),
    .result_overflow (result.overflow)
);

// File: tb/tb_integer_sorter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_sorter
// Self-checking bench for the element sorter. A queue of load items, built up
// front, feeds a falling-edge driver with random gaps; the result sink stalls
// at random as well. Every accepted item goes into an in-bench copy of the
// sorter; each set closed by a last item yields the expected ascending burst,
// which is matched field by field against the results taken at the output.
// ----------------------------------------------------------------------------
module tb_integer_sorter;
    import isrt_pkg::*;

    // One queued load item; hold_idle makes the driver wait until every
    // pending result has drained before it offers the item.
    typedef struct packed {
        value_t value;
        logic   last;
        logic   hold_idle;
    } load_item_t;

    typedef struct packed {
        value_t sorted_value;
        logic   final_res;
        logic   overflow;
    } sorted_item_t;

    localparam int RANDOM_ITEMS = 420;
    localparam int MAX_WAIT     = 17;

    logic clk;
    logic rst_n;

    isrt_in_if  load_ch ();
    isrt_out_if result_ch ();

    integer_sorter dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load_ch),
        .result (result_ch)
    );

    // Stimulus and bench copy of the sorter state
    load_item_t   load_items[$];
    value_t       held_values[$];   // elements of the open set, arrival order
    logic         set_dropped;      // an element of the open set was dropped
    sorted_item_t sorted_due[$];    // results predicted, not yet seen

    // Handshake flags, set at the rising edge, read by the falling-edge drivers
    bit load_fire;
    bit result_fire;

    // Idle pacing: a calm side runs without gaps until its mode flips again
    bit send_calm;
    bit sink_calm;
    int send_wait;
    int sink_wait;

    int error_count;
    int items_taken;
    int sets_closed;
    int full_sets;
    int overflow_sets;
    int results_checked;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int draw_wait(bit calm);
        if (calm)
            return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // Bench copy of the block: store the element (or mark the set dropped),
    // and on the last element emit the set in ascending signed order.
    task automatic collect_element(value_t v, logic last);
        value_t cur;
        int     j;
        if (held_values.size() < CAPACITY)
            held_values.push_back(v);
        else
            set_dropped = 1'b1;
        if (last)
        begin
            // insertion sort; value_t is signed so the compare is signed
            for (int i = 1; i < held_values.size(); i++)
            begin
                cur = held_values[i];
                j   = i;
                while (j > 0 && held_values[j-1] > cur)
                begin
                    held_values[j] = held_values[j-1];
                    j--;
                end
                held_values[j] = cur;
            end
            foreach (held_values[k])
                sorted_due.push_back('{sorted_value: held_values[k],
                                       final_res: (k == held_values.size() - 1),
                                       overflow: set_dropped});
            sets_closed++;
            if (set_dropped)
                overflow_sets++;
            else if (held_values.size() == CAPACITY)
                full_sets++;
            held_values.delete();
            set_dropped = 1'b0;
        end
    endtask

    task automatic check_result(sorted_item_t got);
        sorted_item_t want;
        if (sorted_due.size() == 0)
        begin
            $error("unexpected result: sorted_value=%0d final_res=%0b overflow=%0b",
                   got.sorted_value, got.final_res, got.overflow);
            error_count++;
            return;
        end
        want = sorted_due.pop_front();
        results_checked++;
        if (got.sorted_value !== want.sorted_value)
        begin
            $error("sorted_value: expected %0d, got %0d", want.sorted_value,
                   got.sorted_value);
            error_count++;
        end
        if (got.final_res !== want.final_res)
        begin
            $error("final_res: expected %0b, got %0b", want.final_res, got.final_res);
            error_count++;
        end
        if (got.overflow !== want.overflow)
        begin
            $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
            error_count++;
        end
    endtask

    // Monitor: the load side is handled first, so a result taken in the same
    // cycle as a last item would still find its expectation.
    always @(posedge clk)
    begin
        load_fire   = 1'b0;
        result_fire = 1'b0;
        if (rst_n === 1'b1)
        begin
            if (load_ch.valid === 1'b1 && load_ch.ready === 1'b1)
            begin
                load_fire = 1'b1;
                items_taken++;
                collect_element(load_ch.value, load_ch.last);
            end
            if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            begin
                result_fire = 1'b1;
                check_result('{sorted_value: result_ch.sorted_value,
                               final_res: result_ch.final_res,
                               overflow: result_ch.overflow});
            end
        end
    end

    // Load driver: holds an offered item until taken, then waits its drawn gap.
    always @(negedge clk)
    begin : drive_load
        logic       next_valid;
        load_item_t item;
        next_valid = 1'b0;
        if (rst_n === 1'b1)
        begin
            if (load_ch.valid === 1'b1 && !load_fire)
                next_valid = 1'b1;
            else if (send_wait > 0)
                send_wait--;
            else if (load_items.size() != 0
                     && !(load_items[0].hold_idle && sorted_due.size() != 0))
            begin
                item = load_items.pop_front();
                load_ch.value <= item.value;
                load_ch.last  <= item.last;
                next_valid    = 1'b1;
                if ($urandom_range(0, 31) == 0)
                    send_calm = !send_calm;
                send_wait = draw_wait(send_calm);
            end
        end
        load_ch.valid <= next_valid;
    end

    // Result sink: after each taken result, stall for a freshly drawn count.
    always @(negedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (result_fire)
            begin
                if ($urandom_range(0, 31) == 0)
                    sink_calm = !sink_calm;
                sink_wait = draw_wait(sink_calm);
            end
            if (sink_wait > 0)
            begin
                sink_wait--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
        else
            result_ch.ready <= 1'b0;
    end

    task automatic push_item(value_t v, logic last, logic hold_idle);
        load_items.push_back('{value: v, last: last, hold_idle: hold_idle});
    endtask

    // Extremes and small values are favored so that ties and sign handling
    // show up often; the rest is full-width random.
    function automatic value_t pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2, 3, 4: return $signed($urandom_range(0, 16)) - 8;
            default: return $signed($urandom());
        endcase
    endfunction

    task automatic push_set(int n, logic hold_idle);
        for (int i = 0; i < n; i++)
            push_item(pick_value(), i == n - 1, hold_idle && i == 0);
    endtask

    initial
    begin : stimulus
        int queued;
        int n;
        int pick;
        rst_n           = 1'b0;
        load_ch.valid   = 1'b0;
        load_ch.value   = '0;
        load_ch.last    = 1'b0;
        result_ch.ready = 1'b0;
        set_dropped     = 1'b0;
        send_calm       = 1'b0;
        sink_calm       = 1'b0;
        send_wait       = 0;
        sink_wait       = 0;
        error_count     = 0;

        // Directed: single element, extremes, ties, presorted and reversed
        push_item(32'sh8000_0000, 1'b1, 1'b1);
        push_item(32'sh7FFF_FFFF, 1'b0, 1'b0);
        push_item(32'sh8000_0000, 1'b0, 1'b0);
        push_item(0, 1'b0, 1'b0);
        push_item(-1, 1'b0, 1'b0);
        push_item(1, 1'b1, 1'b0);
        push_item(7, 1'b0, 1'b0);
        push_item(-7, 1'b0, 1'b0);
        push_item(7, 1'b0, 1'b0);
        push_item(7, 1'b1, 1'b0);
        push_item(32'sh7FFF_FFFF, 1'b0, 1'b0);
        push_item(32'sh7FFF_FFFF, 1'b1, 1'b0);
        push_item(0, 1'b0, 1'b0);
        push_item(-1, 1'b1, 1'b0);
        for (int v = -3; v <= 0; v++)
            push_item(v, v == 0, 1'b0);
        for (int v = 3; v >= -1; v--)
            push_item(v, v == -1, 1'b0);

        // Random sets: a full store and an overflowing one first, then mostly
        // short sets with occasional long, full and overflowing ones.
        push_set(CAPACITY, 1'b1);
        push_set(CAPACITY + 3, 1'b0);
        queued = load_items.size();
        while (queued < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 15)
                n = $urandom_range(1, 12);
            else if (pick < 17)
                n = $urandom_range(13, CAPACITY - 1);
            else if (pick < 18)
                n = CAPACITY;
            else
                n = $urandom_range(CAPACITY + 1, CAPACITY + 6);
            push_set(n, $urandom_range(0, 5) == 0);
            queued += n;
        end
        // an open set at the end must produce nothing
        for (int i = 0; i < 3; i++)
            push_item(pick_value(), 1'b0, 1'b0);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (load_items.size() != 0 || load_ch.valid === 1'b1 || sorted_due.size() != 0)
            @(posedge clk);
        // a full drain plus turnaround, to catch stray results
        repeat (CAPACITY + 8) @(posedge clk);

        $display("Loaded %0d items in %0d closed sets (%0d at full store, %0d overflowed).",
                 items_taken, sets_closed, full_sets, overflow_sets);
        $display("Checked %0d sorted results, %0d mismatches.", results_checked, error_count);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog, well beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: integer_sorter.f
hdl/isrt_pkg.sv
hdl/isrt_if.sv
hdl/isrt_cell.sv
hdl/integer_sorter.sv
hdl/isrt_checker.sv
tb/tb_integer_sorter.sv
